/* rtl/core/grts_pkg.sv */
// ----------------------------------------------------------------------------
// grts_pkg: shared types and constants for the grid ray tile search
// Field widths, command/status bundles, configuration register indexes and the
// operation codes of the shared divide/multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package grts_pkg;

	localparam int COORD_W   = 32;  // Q16.16 coordinate
	localparam int TILE_W    = 2;   // tile type code
	localparam int TIDX_W    = 12;  // tile_index field
	localparam int CFG_W     = 16;  // widest config register
	localparam int CFG_IDX_W = 2;
	localparam int MAPDIM_W  = 7;   // map_width / map_height
	localparam int CW_W      = 24;  // tile size in Q8.16
	localparam int MAG_W     = 33;  // segment delta magnitude
	localparam int PROD_W    = 57;  // CW_W x MAG_W product
	localparam int CELL_W    = 26;  // signed cell coordinate
	localparam int POSY_W    = 8;
	localparam int DIV_STEPS = 32;
	localparam int MUL_STEPS = 24;
	localparam int CNT_W     = 6;

	localparam logic OPC_WRITE = 1'b0;

	localparam logic [TILE_W-1:0] TILE_EMPTY   = 2'd0;
	localparam logic [CFG_W-1:0]  TILE_SZ_RST  = 16'd256;
	localparam logic [MAPDIM_W-1:0] MAP_DIM_RST = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_WIDTH,
		CFG_TILE_HEIGHT,
		CFG_MAP_WIDTH,
		CFG_MAP_HEIGHT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MDU_DIV_SX,
		MDU_DIV_SY,
		MDU_DIV_EX,
		MDU_DIV_EY,
		MDU_MUL_NX,
		MDU_MUL_NY,
		MDU_MUL_CX,
		MDU_MUL_CY
	} mdu_op_t;

	typedef struct packed {
		logic [TIDX_W-1:0]         tile_index;
		logic [TILE_W-1:0]         tile_value;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [TILE_W-1:0]         wanted_type;
	} item_t;

	typedef struct packed {
		logic    load;
		logic    clr_step;
		logic    tile_wr;
		logic    mdu_start;
		mdu_op_t mdu_op;
		logic    step;
		logic    rd_cell;
		logic    out_load;
		logic    out_hit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mdu_busy;
		logic mdu_done;
		logic at_end;
		logic steps_done;
		logic cross_stop;
		logic match;
		logic out_busy;
	} dp_stat_t;

	// magnitude of a signed 32-bit value, 2^31 included
	function automatic logic [MAG_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
		return {1'b0, v[COORD_W-1] ? (~v + 32'd1) : v};
	endfunction

endpackage

`default_nettype wire

/* rtl/core/grts_ram.sv */
// ----------------------------------------------------------------------------
// grts_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grts_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/grts_mdu.sv */
// ----------------------------------------------------------------------------
// grts_mdu: shared iterative divide / multiply unit
// Unsigned 32/24 restoring divide, one quotient bit per cycle, or a 33x24
// shift-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grts_mdu (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          is_div,
	input  wire logic [grts_pkg::MAG_W-1:0]    opa,
	input  wire logic [grts_pkg::CW_W-1:0]     opb,
	output      logic                          busy,
	output      logic                          done,
	output      logic [grts_pkg::COORD_W-1:0]  quo,
	output      logic [grts_pkg::CW_W-1:0]     rem,
	output      logic [grts_pkg::PROD_W-1:0]   prod
);

	logic                          busy_q, done_q, div_q;
	logic [grts_pkg::CNT_W-1:0]    cnt_q;
	logic [grts_pkg::COORD_W-1:0]  quo_q;
	logic [grts_pkg::CW_W-1:0]     rem_q, dvs_q, mplier_q;
	logic [grts_pkg::PROD_W-1:0]   prod_q;
	logic [grts_pkg::MAG_W-1:0]    mcand_q;

	logic [grts_pkg::CW_W:0]       shifted, diff;
	logic                          ge;
	logic [grts_pkg::MAG_W:0]      sum;

	always_comb begin
		shifted = {rem_q, quo_q[grts_pkg::COORD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
		sum     = {1'b0, prod_q[grts_pkg::PROD_W-1:grts_pkg::CW_W]}
			+ (mplier_q[0] ? {1'b0, mcand_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= is_div ? grts_pkg::CNT_W'(grts_pkg::DIV_STEPS)
				                 : grts_pkg::CNT_W'(grts_pkg::MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == grts_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q    <= is_div;
			quo_q    <= opa[grts_pkg::COORD_W-1:0];
			rem_q    <= '0;
			dvs_q    <= opb;
			mcand_q  <= opa;
			mplier_q <= opb;
			prod_q   <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? diff[grts_pkg::CW_W-1:0] : shifted[grts_pkg::CW_W-1:0];
				quo_q <= {quo_q[grts_pkg::COORD_W-2:0], ge};
			end else begin
				prod_q   <= {sum, prod_q[grts_pkg::CW_W-1:1]};
				mplier_q <= mplier_q >> 1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

/* rtl/core/grts_dp.sv */
// ----------------------------------------------------------------------------
// grts_dp: datapath of the grid ray tile search
// Config registers, item capture, tile map, setup arithmetic, the DDA walk
// registers (cell, boundary distances, cross-product difference) and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module grts_dp #(
	parameter int MAP_SIDE  = 64,
	parameter int MAX_STEPS = 128
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [grts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [grts_pkg::CFG_W-1:0]        cfg_data,
	input  wire grts_pkg::item_t                   item,
	input  wire grts_pkg::ctrl_cmd_t               cmd,
	output      grts_pkg::dp_stat_t                stat,
	input  wire logic                              m_tready,
	output      logic                              out_valid,
	output      logic                              out_hit,
	output      logic [grts_pkg::COORD_W-1:0]      out_pos_x,
	output      logic [grts_pkg::POSY_W-1:0]       out_pos_y
);

	localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = $clog2(MAP_SIDE);
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int NX_W   = grts_pkg::CW_W + $clog2(MAX_STEPS + 2) + 1;
	localparam int D_W    = grts_pkg::PROD_W + $clog2(MAX_STEPS + 2) + 2;
	localparam int CMP_W  = (NX_W > grts_pkg::MAG_W) ? NX_W : grts_pkg::MAG_W;
	localparam int RW     = grts_pkg::CELL_W + 1;

	// config
	logic [grts_pkg::CFG_W-1:0]    tw_q, th_q;
	logic [grts_pkg::MAPDIM_W-1:0] mw_q, mh_q;
	logic [grts_pkg::CW_W-1:0]     cw, ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= grts_pkg::TILE_SZ_RST;
			th_q <= grts_pkg::TILE_SZ_RST;
			mw_q <= grts_pkg::MAP_DIM_RST;
			mh_q <= grts_pkg::MAP_DIM_RST;
		end else if (cfg_we) begin
			unique case (grts_pkg::cfg_idx_t'(cfg_index))
				grts_pkg::CFG_TILE_WIDTH:  tw_q <= cfg_data;
				grts_pkg::CFG_TILE_HEIGHT: th_q <= cfg_data;
				grts_pkg::CFG_MAP_WIDTH:   mw_q <= cfg_data[grts_pkg::MAPDIM_W-1:0];
				grts_pkg::CFG_MAP_HEIGHT:  mh_q <= cfg_data[grts_pkg::MAPDIM_W-1:0];
				default: ;
			endcase
		end
	end

	// zero tile size acts as one
	assign cw = {(tw_q == '0) ? 16'd1 : tw_q, 8'd0};
	assign ch = {(th_q == '0) ? 16'd1 : th_q, 8'd0};

	// captured item and walk state
	logic [grts_pkg::TIDX_W-1:0]         tile_index_q;
	logic [grts_pkg::TILE_W-1:0]         tile_value_q, wanted_q;
	logic signed [grts_pkg::COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic signed [grts_pkg::COORD_W:0]   dx_q, dy_q;
	logic signed [grts_pkg::CELL_W-1:0]  cx_q, cy_q, endx_q, endy_q;
	logic [grts_pkg::COORD_W-1:0]        posx_q;
	logic [NX_W-1:0]                     nx_q, ny_q;
	logic signed [D_W-1:0]               d_q;
	logic [grts_pkg::PROD_W-1:0]         incx_q, incy_q;
	logic [STEP_W-1:0]                   steps_q;
	logic                                inrange_q;
	logic [ADDR_W-1:0]                   clr_q;

	logic [grts_pkg::MAG_W-1:0] adx, ady;
	logic stepx_pos, stepx_neg, stepx_zero, stepy_pos, stepy_neg, stepy_zero;

	always_comb begin
		adx = dx_q[grts_pkg::COORD_W] ? grts_pkg::MAG_W'(-dx_q) : grts_pkg::MAG_W'(dx_q);
		ady = dy_q[grts_pkg::COORD_W] ? grts_pkg::MAG_W'(-dy_q) : grts_pkg::MAG_W'(dy_q);
		stepx_zero = (dx_q == '0);
		stepx_neg  = dx_q[grts_pkg::COORD_W];
		stepx_pos  = !stepx_zero && !stepx_neg;
		stepy_zero = (dy_q == '0);
		stepy_neg  = dy_q[grts_pkg::COORD_W];
		stepy_pos  = !stepy_zero && !stepy_neg;
	end

	// shared divide / multiply unit and its operand select
	logic [grts_pkg::MAG_W-1:0]   opa;
	logic [grts_pkg::CW_W-1:0]    opb;
	logic                         is_div, neg;
	logic                         mdu_busy, mdu_done;
	logic [grts_pkg::COORD_W-1:0] mdu_quo;
	logic [grts_pkg::CW_W-1:0]    mdu_rem;
	logic [grts_pkg::PROD_W-1:0]  mdu_prod;

	always_comb begin
		is_div = 1'b1;
		neg    = 1'b0;
		unique case (cmd.mdu_op)
			grts_pkg::MDU_DIV_SX: begin
				opa = grts_pkg::mag32(sx_q); opb = cw; neg = sx_q[grts_pkg::COORD_W-1];
			end
			grts_pkg::MDU_DIV_SY: begin
				opa = grts_pkg::mag32(sy_q); opb = ch; neg = sy_q[grts_pkg::COORD_W-1];
			end
			grts_pkg::MDU_DIV_EX: begin
				opa = grts_pkg::mag32(ex_q); opb = cw; neg = ex_q[grts_pkg::COORD_W-1];
			end
			grts_pkg::MDU_DIV_EY: begin
				opa = grts_pkg::mag32(ey_q); opb = ch; neg = ey_q[grts_pkg::COORD_W-1];
			end
			grts_pkg::MDU_MUL_NX: begin
				opa = ady; opb = nx_q[grts_pkg::CW_W-1:0]; is_div = 1'b0;
			end
			grts_pkg::MDU_MUL_NY: begin
				opa = adx; opb = ny_q[grts_pkg::CW_W-1:0]; is_div = 1'b0;
			end
			grts_pkg::MDU_MUL_CX: begin
				opa = ady; opb = cw; is_div = 1'b0;
			end
			grts_pkg::MDU_MUL_CY: begin
				opa = adx; opb = ch; is_div = 1'b0;
			end
			default: begin
				opa = '0; opb = cw;
			end
		endcase
	end

	grts_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mdu_start),
		.is_div (is_div),
		.opa    (opa),
		.opb    (opb),
		.busy   (mdu_busy),
		.done   (mdu_done),
		.quo    (mdu_quo),
		.rem    (mdu_rem),
		.prod   (mdu_prod)
	);

	// floor quotient and nonnegative remainder from the magnitude divide
	logic signed [grts_pkg::CELL_W-1:0] quo_c, fq;
	logic [grts_pkg::CW_W-1:0]          frem;
	logic                               rnz;
	logic [NX_W-1:0]                    nx_init, ny_init;
	logic signed [D_W-1:0]              prod_ext, incx_ext, incy_ext;

	always_comb begin
		quo_c = grts_pkg::CELL_W'(mdu_quo);
		rnz   = |mdu_rem;
		fq    = !neg ? quo_c : (rnz ? ~quo_c : -quo_c);
		frem  = (neg && rnz) ? opb - mdu_rem : mdu_rem;
		nx_init = stepx_pos ? NX_W'(cw - frem) : (stepx_neg ? NX_W'(frem) : '0);
		ny_init = stepy_pos ? NX_W'(ch - frem) : (stepy_neg ? NX_W'(frem) : '0);
		prod_ext = $signed({{(D_W - grts_pkg::PROD_W){1'b0}}, mdu_prod});
		incx_ext = $signed({{(D_W - grts_pkg::PROD_W){1'b0}}, incx_q});
		incy_ext = $signed({{(D_W - grts_pkg::PROD_W){1'b0}}, incy_q});
	end

	// walk decisions; ties step y
	logic take_x;
	logic cross_stop;

	always_comb begin
		take_x = stepx_zero ? 1'b0 : (stepy_zero ? 1'b1 : d_q[D_W-1]);
		cross_stop = take_x ? (CMP_W'(nx_q) > CMP_W'(adx))
		                    : (stepy_zero || (CMP_W'(ny_q) > CMP_W'(ady)));
	end

	// cell addressing, rows flipped
	logic [RW-1:0]     row, wlim, hlim;
	logic              in_range;
	logic [ADDR_W-1:0] rd_addr, tile_addr;
	logic              wr_ok;

	always_comb begin
		row  = RW'(mh_q) - RW'(1) - RW'(cy_q);
		wlim = (RW'(mw_q) > RW'(MAP_SIDE)) ? RW'(MAP_SIDE) : RW'(mw_q);
		hlim = (RW'(mh_q) > RW'(MAP_SIDE)) ? RW'(MAP_SIDE) : RW'(mh_q);
		in_range = !cx_q[grts_pkg::CELL_W-1] && ({1'b0, cx_q} < wlim)
			&& !row[RW-1] && (row < hlim);
		rd_addr  = ADDR_W'(ADDR_W'(row[IDX_W-1:0]) * ADDR_W'(MAP_SIDE))
			+ ADDR_W'(cx_q[IDX_W-1:0]);
		tile_addr = ADDR_W'(tile_index_q);
		wr_ok     = {20'd0, tile_index_q} < 32'(DEPTH);
	end

	logic [grts_pkg::TILE_W-1:0] ram_rdata;

	grts_ram #(
		.WIDTH (grts_pkg::TILE_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (cmd.clr_step || (cmd.tile_wr && wr_ok)),
		.waddr (cmd.clr_step ? clr_q : tile_addr),
		.wdata (cmd.clr_step ? grts_pkg::TILE_EMPTY : tile_value_q),
		.re    (cmd.rd_cell),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// control registers
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				steps_q <= '0;
			end else if (cmd.step) begin
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	logic                         out_hit_q;
	logic [grts_pkg::COORD_W-1:0] out_x_q;
	logic [grts_pkg::POSY_W-1:0]  out_y_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tile_index_q <= item.tile_index;
			tile_value_q <= item.tile_value;
			wanted_q     <= item.wanted_type;
			sx_q <= item.start_x;
			sy_q <= item.start_y;
			ex_q <= item.end_x;
			ey_q <= item.end_y;
			dx_q <= 33'(item.end_x) - 33'(item.start_x);
			dy_q <= 33'(item.end_y) - 33'(item.start_y);
		end
		if (cmd.rd_cell) inrange_q <= in_range;
		if (mdu_done) begin
			unique case (cmd.mdu_op)
				grts_pkg::MDU_DIV_SX: begin
					cx_q   <= fq;
					posx_q <= sx_q - 32'(frem);
					nx_q   <= nx_init;
				end
				grts_pkg::MDU_DIV_SY: begin
					cy_q <= fq;
					ny_q <= ny_init;
				end
				grts_pkg::MDU_DIV_EX: endx_q <= fq;
				grts_pkg::MDU_DIV_EY: endy_q <= fq;
				grts_pkg::MDU_MUL_NX: d_q    <= prod_ext;
				grts_pkg::MDU_MUL_NY: d_q    <= d_q - prod_ext;
				grts_pkg::MDU_MUL_CX: incx_q <= mdu_prod;
				grts_pkg::MDU_MUL_CY: incy_q <= mdu_prod;
				default: ;
			endcase
		end else if (cmd.step) begin
			if (take_x) begin
				nx_q   <= nx_q + NX_W'(cw);
				cx_q   <= stepx_pos ? cx_q + grts_pkg::CELL_W'(1) : cx_q - grts_pkg::CELL_W'(1);
				posx_q <= stepx_pos ? posx_q + 32'(cw) : posx_q - 32'(cw);
				d_q    <= d_q + incx_ext;
			end else begin
				ny_q <= ny_q + NX_W'(ch);
				cy_q <= stepy_pos ? cy_q + grts_pkg::CELL_W'(1) : cy_q - grts_pkg::CELL_W'(1);
				d_q  <= d_q - incy_ext;
			end
		end
		if (cmd.out_load) begin
			out_hit_q <= cmd.out_hit;
			out_x_q   <= cmd.out_hit ? posx_q : '0;
			out_y_q   <= cmd.out_hit ? cy_q[grts_pkg::POSY_W-1:0] : '0;
		end
	end

	always_comb begin
		stat.clr_last   = (clr_q == ADDR_W'(DEPTH - 1));
		stat.mdu_busy   = mdu_busy;
		stat.mdu_done   = mdu_done;
		stat.at_end     = (cx_q == endx_q) && (cy_q == endy_q);
		stat.steps_done = (steps_q >= STEP_W'(MAX_STEPS));
		stat.cross_stop = cross_stop;
		stat.match      = inrange_q ? (ram_rdata == wanted_q)
		                            : (wanted_q == grts_pkg::TILE_EMPTY);
		stat.out_busy   = out_valid_q && !m_tready;
	end

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_pos_x = out_x_q;
	assign out_pos_y = out_y_q;

endmodule

`default_nettype wire

/* rtl/core/grts_ctrl.sv */
// ----------------------------------------------------------------------------
// grts_ctrl: controller of the grid ray tile search
// Sequences map clear, tile writes, the setup divides and multiplies, the
// cell-by-cell walk and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module grts_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 opcode,
	output      logic                 s_tready,
	input  wire grts_pkg::dp_stat_t   stat,
	output      grts_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_WR,
		ST_LAUNCH,
		ST_WAIT,
		ST_DECIDE,
		ST_READ,
		ST_CHECK,
		ST_FIN
	} state_t;

	state_t             state_q;
	grts_pkg::mdu_op_t  op_q;
	logic               hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			op_q    <= grts_pkg::MDU_DIV_SX;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: if (stat.clr_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					hit_q <= 1'b0;
					op_q  <= grts_pkg::MDU_DIV_SX;
					if (s_tvalid) begin
						state_q <= (opcode == grts_pkg::OPC_WRITE) ? ST_WR : ST_LAUNCH;
					end
				end
				ST_WR:     state_q <= ST_FIN;
				ST_LAUNCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (stat.mdu_done) begin
						if (op_q == grts_pkg::MDU_MUL_CY) begin
							state_q <= ST_DECIDE;
						end else begin
							op_q    <= grts_pkg::mdu_op_t'(op_q + 1'b1);
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_DECIDE: begin
					if (stat.at_end || stat.steps_done || stat.cross_stop) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (stat.match) begin
						hit_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_FIN: if (!stat.out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mdu_op = op_q;
		cmd.out_hit = hit_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLR:  cmd.clr_step = 1'b1;
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_WR:     cmd.tile_wr = 1'b1;
			ST_LAUNCH: cmd.mdu_start = 1'b1;
			ST_DECIDE: cmd.step = !(stat.at_end || stat.steps_done || stat.cross_stop);
			ST_READ:   cmd.rd_cell = 1'b1;
			ST_FIN:    cmd.out_load = !stat.out_busy;
			default: ;
		endcase
	end

	// the shared unit is never restarted mid-operation
	a_mdu_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mdu_start |-> !stat.mdu_busy)
		else $error("divide/multiply unit started while busy");

	// a result never overwrites one that has not been taken
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("result register overwritten");

	// map data is checked only the cycle after its read was issued
	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> $past(cmd.rd_cell))
		else $error("cell checked without a read");

endmodule

`default_nettype wire

/* rtl/core/grid_ray_tile_search.sv */
// ----------------------------------------------------------------------------
// grid_ray_tile_search: tile map with DDA ray walk search
// Top level: stream ports, config write port, controller and datapath.
// ----------------------------------------------------------------------------
// A 2-bit tile map of MAP_SIDE x MAP_SIDE entries (4096 by default) is cleared
// to empty after reset by a sweep over every entry, during which s_tready stays
// low. A write beat (tuser 0) stores one tile and then presents one all-zero
// result beat once the output register is free. A trace beat (tuser 1)
// walks the grid cells that the segment from start to end crosses, skipping
// the start cell, and returns the first cell of the wanted type: x times tile
// width and cell y. Setup runs four divides and four multiplies on one shared
// iterative unit; then each cell crossed runs a decide, a map read and a compare,
// at most MAX_STEPS cells. One item is in work at a time; a finished result
// sits in the output register while the next beat is accepted.
`default_nettype none

module grid_ray_tile_search #(
	parameter int MAP_SIDE  = 64,
	parameter int MAX_STEPS = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// config write port: 0 tile_width, 1 tile_height, 2 map_width, 3 map_height
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	// input beats
	input  wire logic          s_tvalid,
	output      logic          s_tready,
	// [11:0] tile_index, [13:12] tile_value, [45:14] start_x, [77:46] start_y,
	// [109:78] end_x, [141:110] end_y, [143:142] wanted_type, [151:144] zero
	input  wire logic [151:0]  s_tdata,
	// [0] opcode
	input  wire logic          s_tuser,
	// result beats
	output      logic          m_tvalid,
	input  wire logic          m_tready,
	// [31:0] hit_pos_x, [39:32] hit_pos_y
	output      logic [39:0]   m_tdata,
	// [0] hit
	output      logic          m_tuser
);

	grts_pkg::item_t      item;
	grts_pkg::ctrl_cmd_t  cmd;
	grts_pkg::dp_stat_t   stat;

	logic [grts_pkg::COORD_W-1:0] pos_x;
	logic [grts_pkg::POSY_W-1:0]  pos_y;

	always_comb begin
		item.tile_index  = s_tdata[11:0];
		item.tile_value  = s_tdata[13:12];
		item.start_x     = s_tdata[45:14];
		item.start_y     = s_tdata[77:46];
		item.end_x       = s_tdata[109:78];
		item.end_y       = s_tdata[141:110];
		item.wanted_type = s_tdata[143:142];
	end

	grts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	grts_dp #(
		.MAP_SIDE  (MAP_SIDE),
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_hit   (m_tuser),
		.out_pos_x (pos_x),
		.out_pos_y (pos_y)
	);

	assign m_tdata = {pos_y, pos_x};

endmodule

`default_nettype wire
